### rtl/core/nsr_pkg.sv
// ----------------------------------------------------------------------------
// Newton square root package
// Fixed field widths and sequencer state encoding.
// ----------------------------------------------------------------------------
package nsr_pkg;

   localparam int OPERAND_W = 32;
   localparam int ROOT_W    = 25;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIV    = 3'b010,
      ST_UPDATE = 3'b100
   } nsr_state_type;

endpackage

### rtl/core/nsr_div.sv
// ----------------------------------------------------------------------------
// Newton square root divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nsr_div #(
   parameter int W = 47
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int CNT_W = $clog2(W);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   logic [W:0]       shifted;
   logic [W+1:0]     diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (diff[W+1]) begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end else begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/core/newton_square_root.sv
// ----------------------------------------------------------------------------
// Newton square root
// Fixed-point square root by Newton-Raphson iteration on a single divider.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. A negative or zero
// operand gives its result in the next cycle with busy staying low. Otherwise
// busy stays high while the guess is refined from 1.0: each Newton step is one
// serial divide of 31+FRAC_BITS quotient bits followed by an update state, and
// at most MAX_ITERATIONS steps run. The result appears on rsp_ for exactly
// one cycle with rsp_valid high; the receiver cannot stall it, so it must be
// captured then.
module newton_square_root
   import nsr_pkg::*;
#(
   parameter int FRAC_BITS      = 16,
   parameter int MAX_ITERATIONS = 40
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [OPERAND_W-1:0] req_operand,
   output logic                        rsp_valid,
   output logic signed [ROOT_W-1:0]    rsp_root,
   output logic                        rsp_cap_reached
);

   localparam int NUM_W  = OPERAND_W - 1 + FRAC_BITS;
   localparam int ITER_W = $clog2(MAX_ITERATIONS);

   nsr_state_type     state_ff, state_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  guess_ff, guess_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic              div_start_ff, div_start_in;
   logic              valid_ff, valid_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic              cap_ff, cap_in;

   logic              div_done;
   logic [NUM_W-1:0]  div_quo;
   logic [NUM_W:0]    sum;
   logic [NUM_W-1:0]  nxt;
   logic [NUM_W:0]    step;

   nsr_div #(.W(NUM_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (num_ff),
      .divisor  (guess_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      sum  = {1'b0, guess_ff} + {1'b0, quo_ff};
      nxt  = sum[NUM_W:1];
      if (nxt == '0) begin
         nxt = NUM_W'(1);
      end
      step = {1'b0, nxt} - {1'b0, guess_ff};

      state_in     = state_ff;
      num_in       = num_ff;
      guess_in     = guess_ff;
      iter_in      = iter_ff;
      quo_in       = quo_ff;
      div_start_in = 1'b0;
      valid_in     = 1'b0;
      root_in      = root_ff;
      cap_in       = cap_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_operand[OPERAND_W-1]) begin
                  valid_in = 1'b1;
                  root_in  = ROOT_W'(0) - (ROOT_W'(1) << FRAC_BITS);
                  cap_in   = 1'b0;
               end else if (req_operand == '0) begin
                  valid_in = 1'b1;
                  root_in  = '0;
                  cap_in   = 1'b0;
               end else begin
                  num_in       = NUM_W'(req_operand[OPERAND_W-2:0]) << FRAC_BITS;
                  guess_in     = NUM_W'(1) << FRAC_BITS;
                  iter_in      = '0;
                  div_start_in = 1'b1;
                  state_in     = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               quo_in   = div_quo;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (step == '0 || step == (NUM_W+1)'(1)) begin
               valid_in = 1'b1;
               root_in  = guess_ff[ROOT_W-1:0];
               cap_in   = 1'b0;
               state_in = ST_IDLE;
            end else begin
               guess_in = nxt;
               if (iter_ff == ITER_W'(MAX_ITERATIONS - 1)) begin
                  valid_in = 1'b1;
                  root_in  = nxt[ROOT_W-1:0];
                  cap_in   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  iter_in      = iter_ff + 1'b1;
                  div_start_in = 1'b1;
                  state_in     = ST_DIV;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_start_ff <= div_start_in;
         valid_ff     <= valid_in;
      end
      num_ff   <= num_in;
      guess_ff <= guess_in;
      iter_ff  <= iter_in;
      quo_ff   <= quo_in;
      root_ff  <= root_in;
      cap_ff   <= cap_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_root        = root_ff;
   assign rsp_cap_reached = cap_ff;

endmodule
